// ----- sv/md5_pkg.sv -----
// ----------------------------------------------------------------------------
// md5_pkg: shared types, constants and tables of the MD5 digest unit
// Beat payloads, the working-state struct, the controller states, the sine
// constant table and the per-step message index and rotate amount.
// ----------------------------------------------------------------------------
package md5_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} md5_in_t;

	typedef struct packed {
		logic [63:0] digest_half;
		logic        last_half;
	} md5_out_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
	} md5_abcd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_COMP,
		ST_FOLD,
		ST_PAD,
		ST_DONE
	} md5_state_t;

	localparam int unsigned CNT_W = 61;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;

	localparam logic [7:0] PAD_BYTE  = 8'h80;
	localparam logic [5:0] LEN_START = 6'd56;
	localparam logic [3:0] LEN_LO_W  = 4'd14;
	localparam logic [3:0] LEN_HI_W  = 4'd15;
	localparam logic [5:0] LAST_STEP = 6'd63;

	localparam logic [31:0] SINE_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	// message word used by a step
	function automatic logic [3:0] msg_idx(input logic [5:0] step);
		logic [3:0] s;
		logic [3:0] r;
		s = step[3:0];
		case (step[5:4])
			2'd0:    r = s;
			2'd1:    r = s * 4'd5 + 4'd1;
			2'd2:    r = s * 4'd3 + 4'd5;
			default: r = s * 4'd7;
		endcase
		return r;
	endfunction

	// left rotate amount of a step
	function automatic logic [4:0] rot_amt(input logic [5:0] step);
		logic [4:0] r;
		case ({step[5:4], step[1:0]})
			4'd0:    r = 5'd7;
			4'd1:    r = 5'd12;
			4'd2:    r = 5'd17;
			4'd3:    r = 5'd22;
			4'd4:    r = 5'd5;
			4'd5:    r = 5'd9;
			4'd6:    r = 5'd14;
			4'd7:    r = 5'd20;
			4'd8:    r = 5'd4;
			4'd9:    r = 5'd11;
			4'd10:   r = 5'd16;
			4'd11:   r = 5'd23;
			4'd12:   r = 5'd6;
			4'd13:   r = 5'd10;
			4'd14:   r = 5'd15;
			default: r = 5'd21;
		endcase
		return r;
	endfunction

endpackage

// ----- sv/md5_message_digest_unit.sv -----
// ----------------------------------------------------------------------------
// md5_message_digest_unit: MD5 digest of a byte stream
// Collects bytes into a 16-word block memory, compresses each full block one
// step per cycle, pads and appends the bit length at end of message, and
// returns the 128-bit digest as two 64-bit beats.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload                                  | beats
//  --------+----------------------+------------------------------------------+-------------
//  in      | in_valid / in_ready  | data_byte, byte_present, end_of_message  | one per item
//  out     | out_valid / out_ready| digest_half, last_half                   | two per message
//
// Bytes are accepted back to back while a block fills. The beat that
// completes a 64-byte block holds the input through LOAD (first block
// memory read), COMP (64 compression steps, one per cycle, limited by the
// single read port of the block memory) and FOLD (fold into the chaining
// words). End of message adds a pad pass writing the padded words (up to
// 16) in turn plus a compression, twice when the length no longer fits,
// and DONE to load the digest into the output register. Reset: asynchronous,
// clears the controller and byte count, presets the chaining words to the
// IV; the block memory is not cleared, since padding overwrites every word
// that a compression reads. Stalls: the digest sits in an output register,
// so a stalled output only holds the input once the next digest is ready.
//
module md5_message_digest_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  md5_pkg::md5_in_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output md5_pkg::md5_out_t out_data
);

	// controller
	md5_pkg::md5_state_t state_q, state_d;

	logic [md5_pkg::CNT_W-1:0] cnt_q;
	logic [md5_pkg::CNT_W-1:0] cnt_inc;
	logic [md5_pkg::CNT_W-1:0] cnt_nx;
	logic                      fin_q;
	logic                      padded_q;
	logic                      lendone_q;
	logic [3:0]                pw_q;
	logic [5:0]                step_q;

	// chaining words and working state
	logic [31:0]        h_q [4];
	md5_pkg::md5_abcd_t work_q;
	md5_pkg::md5_abcd_t work_nxt;

	// partial word of incoming bytes
	logic [31:0] acc_q;

	// block memory
	logic [31:0] blk_mem [16];
	logic [31:0] rd_data_q;
	logic [3:0]  rd_addr;
	logic        wr_en;
	logic [3:0]  wr_addr;
	logic [31:0] wr_data;

	// output register
	logic         out_valid_q;
	logic         half_q;
	logic [127:0] dig_q;

	logic        in_acc;
	logic        byte_acc;
	logic        blk_full;
	logic        lenpass;
	logic        marker;
	logic        done_leave;
	logic [31:0] pad_word;
	logic [63:0] bit_len;

	assign in_ready = (state_q == md5_pkg::ST_IDLE);
	assign in_acc   = in_valid & in_ready;
	assign byte_acc = in_acc & in_data.byte_present;
	assign cnt_inc  = cnt_q + md5_pkg::CNT_W'(1);
	assign cnt_nx   = byte_acc ? cnt_inc : cnt_q;
	assign blk_full = byte_acc & (cnt_inc[5:0] == 6'd0);

	assign bit_len  = {cnt_q, 3'b000};
	// length fits in this pad pass when it is the second one or space remains
	assign lenpass  = padded_q | (cnt_q[5:0] < md5_pkg::LEN_START);
	assign marker   = ~padded_q & (pw_q == cnt_q[5:2]);

	assign done_leave = (state_q == md5_pkg::ST_DONE) & ~out_valid_q;

	// build one padding word: leftover bytes, the 0x80 marker, zeros, length
	always_comb begin
		pad_word = '0;
		if (marker) begin
			for (int l = 0; l < 4; l++) begin
				if (2'(l) < cnt_q[1:0]) begin
					pad_word[8*l +: 8] = acc_q[8*l +: 8];
				end else if (2'(l) == cnt_q[1:0]) begin
					pad_word[8*l +: 8] = md5_pkg::PAD_BYTE;
				end
			end
		end
		if (lenpass && pw_q == md5_pkg::LEN_LO_W) begin
			pad_word = bit_len[31:0];
		end else if (lenpass && pw_q == md5_pkg::LEN_HI_W) begin
			pad_word = bit_len[63:32];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			md5_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (blk_full) begin
						state_d = md5_pkg::ST_LOAD;
					end else if (in_data.end_of_message) begin
						state_d = md5_pkg::ST_PAD;
					end
				end
			end
			md5_pkg::ST_LOAD: state_d = md5_pkg::ST_COMP;
			md5_pkg::ST_COMP: begin
				if (step_q == md5_pkg::LAST_STEP) begin
					state_d = md5_pkg::ST_FOLD;
				end
			end
			md5_pkg::ST_FOLD: begin
				if (!fin_q) begin
					state_d = md5_pkg::ST_IDLE;
				end else if (lendone_q) begin
					state_d = md5_pkg::ST_DONE;
				end else begin
					state_d = md5_pkg::ST_PAD;
				end
			end
			md5_pkg::ST_PAD: begin
				if (pw_q == md5_pkg::LEN_HI_W) begin
					state_d = md5_pkg::ST_LOAD;
				end
			end
			md5_pkg::ST_DONE: begin
				if (!out_valid_q) begin
					state_d = md5_pkg::ST_IDLE;
				end
			end
			default: state_d = md5_pkg::ST_IDLE;
		endcase
	end

	// memory controls per state
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cnt_q[5:2];
		wr_data = {in_data.data_byte, acc_q[23:0]};
		rd_addr = md5_pkg::msg_idx(step_q + 6'd1);
		case (state_q)
			md5_pkg::ST_IDLE: begin
				// write a word once its fourth byte arrives
				wr_en = byte_acc & (cnt_q[1:0] == 2'd3);
			end
			md5_pkg::ST_LOAD: begin
				rd_addr = md5_pkg::msg_idx(6'd0);
			end
			md5_pkg::ST_PAD: begin
				wr_en   = 1'b1;
				wr_addr = pw_q;
				wr_data = pad_word;
			end
			default: wr_en = 1'b0;
		endcase
	end

	// block memory: one write port, one registered read port; writes and
	// compression reads never overlap in time
	always_ff @(posedge clk) begin
		if (wr_en) begin
			blk_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= blk_mem[rd_addr];
	end

	md5_step u_step (
		.cur  (work_q),
		.word (rd_data_q),
		.step (step_q),
		.nxt  (work_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= md5_pkg::ST_IDLE;
			cnt_q     <= '0;
			fin_q     <= 1'b0;
			padded_q  <= 1'b0;
			lendone_q <= 1'b0;
			pw_q      <= '0;
			step_q    <= '0;
			h_q[0]    <= md5_pkg::IV_A;
			h_q[1]    <= md5_pkg::IV_B;
			h_q[2]    <= md5_pkg::IV_C;
			h_q[3]    <= md5_pkg::IV_D;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				cnt_q <= cnt_nx;
				pw_q  <= cnt_nx[5:2];
				if (in_data.end_of_message) begin
					fin_q <= 1'b1;
				end
			end
			if (state_q == md5_pkg::ST_LOAD) begin
				step_q <= '0;
			end else if (state_q == md5_pkg::ST_COMP) begin
				step_q <= step_q + 6'd1;
			end
			if (state_q == md5_pkg::ST_PAD) begin
				pw_q <= pw_q + 4'd1;
				if (pw_q == md5_pkg::LEN_HI_W) begin
					padded_q  <= 1'b1;
					lendone_q <= lenpass;
				end
			end
			if (state_q == md5_pkg::ST_FOLD) begin
				// second pad pass always starts at word zero
				pw_q   <= '0;
				h_q[0] <= h_q[0] + work_q.a;
				h_q[1] <= h_q[1] + work_q.b;
				h_q[2] <= h_q[2] + work_q.c;
				h_q[3] <= h_q[3] + work_q.d;
			end
			if (done_leave) begin
				// restore the initial vector for the next message
				cnt_q     <= '0;
				fin_q     <= 1'b0;
				padded_q  <= 1'b0;
				lendone_q <= 1'b0;
				h_q[0]    <= md5_pkg::IV_A;
				h_q[1]    <= md5_pkg::IV_B;
				h_q[2]    <= md5_pkg::IV_C;
				h_q[3]    <= md5_pkg::IV_D;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (byte_acc) begin
			acc_q[8*cnt_q[1:0] +: 8] <= in_data.data_byte;
		end
		if (state_q == md5_pkg::ST_LOAD) begin
			work_q <= '{a: h_q[0], b: h_q[1], c: h_q[2], d: h_q[3]};
		end else if (state_q == md5_pkg::ST_COMP) begin
			work_q <= work_nxt;
		end
		if (done_leave) begin
			dig_q <= {h_q[3], h_q[2], h_q[1], h_q[0]};
		end
	end

	// output beats: low half first, then the high half
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			half_q      <= 1'b0;
		end else if (done_leave) begin
			out_valid_q <= 1'b1;
			half_q      <= 1'b0;
		end else if (out_valid_q && out_ready) begin
			if (half_q) begin
				out_valid_q <= 1'b0;
				half_q      <= 1'b0;
			end else begin
				half_q <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		out_data.digest_half = half_q ? dig_q[127:64] : dig_q[63:0];
		out_data.last_half   = half_q;
	end

endmodule

// ----- sv/md5_step.sv -----
// ----------------------------------------------------------------------------
// md5_step: one MD5 compression step
// Mixes the working words with one message word and one sine constant and
// returns the rotated working state for the next step.
// ----------------------------------------------------------------------------
module md5_step (
	input  md5_pkg::md5_abcd_t cur,
	input  logic [31:0]        word,
	input  logic [5:0]         step,
	output md5_pkg::md5_abcd_t nxt
);

	logic [31:0] mix;
	logic [31:0] sum;
	logic [63:0] dbl;
	logic [31:0] rot;

	always_comb begin
		case (step[5:4])
			2'd0:    mix = (cur.b & cur.c) | (~cur.b & cur.d);
			2'd1:    mix = (cur.b & cur.d) | (cur.c & ~cur.d);
			2'd2:    mix = cur.b ^ cur.c ^ cur.d;
			default: mix = cur.c ^ (cur.b | ~cur.d);
		endcase
		sum = cur.a + mix + word + md5_pkg::SINE_K[step];
		// rotate left through a doubled word
		dbl = {sum, sum} << md5_pkg::rot_amt(step);
		rot = dbl[63:32];
		nxt.a = cur.d;
		nxt.b = cur.b + rot;
		nxt.c = cur.b;
		nxt.d = cur.c;
	end

endmodule
